// ===== hw/rtl/life_cell_with_phase_handshake_assert.svh =====
// Assertion macros shared by the life cell RTL.
// Depends on nothing; included by modules that carry concurrent assertions.
`ifndef LIFE_CELL_WITH_PHASE_HANDSHAKE_ASSERT_SVH
`define LIFE_CELL_WITH_PHASE_HANDSHAKE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCPH_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LCPH_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lcph_pkg.sv =====
// Package for the life cell with phase handshake: widths, codes and defaults.
// Depends on nothing; used by life_cell_with_phase_handshake.
`default_nettype none

package lcph_pkg;

    // Fixed field widths.
    localparam int NEIGHBOR_COUNT_DEF = 8;
    localparam int SLOT_W             = 3;
    localparam int PHASE_W            = 8;
    localparam int NEXT_W             = 2;
    localparam int COLOR_W            = 3;
    localparam int CFG_IDX_W          = 2;

    // Transaction command codes.
    typedef enum logic [0:0] {
        CMD_MESSAGE  = 1'b0,
        CMD_EVALUATE = 1'b1
    } cmd_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_ALIVE    = 2'd1;

    // Next-state codes.
    localparam logic [NEXT_W-1:0] NEXT_DEAD    = 2'd0;
    localparam logic [NEXT_W-1:0] NEXT_ALIVE   = 2'd1;
    localparam logic [NEXT_W-1:0] NEXT_UNKNOWN = 2'd2;

    // LED color codes.
    localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd1;
    localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd2;
    localparam logic [COLOR_W-1:0] COLOR_CYAN   = 3'd3;
    localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd4;

endpackage

`default_nettype wire

// ===== hw/rtl/life_cell_with_phase_handshake.sv =====
// Top level of one Conway life cell with a calculate/pass/allow phase barrier.
// Depends on lcph_pkg and life_cell_with_phase_handshake_assert.svh.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | command, slot, phase, four flags
//   m_      | out       | m_valid / m_ready  | alive, next, flags, phase, LED
//   cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
// One transaction enters per cycle unless a stalled result blocks the input register;
// it sits in the input register while the life rule and phase checks settle in one
// pass, and moves on into the state and result registers once the result register is free.
// Reset is synchronous (aresetn low) and takes effect at once; no clearing pass.
// A stalled result holds while the input register still accepts one more item.
`default_nettype none

module life_cell_with_phase_handshake #(
    parameter int NEIGHBOR_COUNT = lcph_pkg::NEIGHBOR_COUNT_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Configuration write port
    input  wire logic                           cfg_wr_en,
    input  wire logic [lcph_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [NEIGHBOR_COUNT-1:0]      cfg_wdata,
    // Input channel
    input  wire logic                           s_valid,
    output      logic                           s_ready,
    input  wire logic                           s_command,
    input  wire logic [lcph_pkg::SLOT_W-1:0]    s_sender_slot,
    input  wire logic [lcph_pkg::PHASE_W-1:0]   s_msg_phase,
    input  wire logic                           s_msg_alive,
    input  wire logic                           s_msg_calc,
    input  wire logic                           s_msg_passed,
    input  wire logic                           s_msg_allow,
    // Result channel
    output      logic                           m_valid,
    input  wire logic                           m_ready,
    output      logic                           m_out_alive,
    output      logic [lcph_pkg::NEXT_W-1:0]    m_out_next,
    output      logic                           m_out_calc,
    output      logic                           m_out_passed,
    output      logic                           m_out_allow,
    output      logic [lcph_pkg::PHASE_W-1:0]   m_out_phase,
    output      logic [lcph_pkg::COLOR_W-1:0]   m_led_color
);

    `include "life_cell_with_phase_handshake_assert.svh"

    localparam int CNT_W = $clog2(NEIGHBOR_COUNT + 1);
    localparam int PW    = lcph_pkg::PHASE_W;

    // Input register.
    logic                             in_valid_reg;
    lcph_pkg::cmd_t                   in_cmd_reg;
    logic [lcph_pkg::SLOT_W-1:0]      in_slot_reg;
    logic [PW-1:0]                    in_phase_reg;
    logic                             in_alive_reg;
    logic                             in_calc_reg;
    logic                             in_passed_reg;
    logic                             in_allow_reg;

    // Configuration and cell state.
    logic [NEIGHBOR_COUNT-1:0]        present_reg;
    logic                             alive_reg,  alive_next;
    logic [lcph_pkg::NEXT_W-1:0]      cnext_reg,  cnext_next;
    logic                             calc_reg,   calc_next;
    logic                             passed_reg, passed_next;
    logic                             allow_reg,  allow_next;
    logic [PW-1:0]                    phase_reg,  phase_next;
    logic [lcph_pkg::COLOR_W-1:0]     color_reg,  color_next;

    // Neighbor records; a state of unknown is kept as known = 0.
    logic [NEIGHBOR_COUNT-1:0]        nknown_reg,  nknown_next;
    logic [NEIGHBOR_COUNT-1:0]        nalive_reg,  nalive_next;
    logic [NEIGHBOR_COUNT-1:0]        ncalc_reg,   ncalc_next;
    logic [NEIGHBOR_COUNT-1:0]        npassed_reg, npassed_next;
    logic [NEIGHBOR_COUNT-1:0]        nallow_reg,  nallow_next;

    // Result register.
    logic                             out_valid_reg;
    logic                             out_alive_reg;
    logic [lcph_pkg::NEXT_W-1:0]      out_next_reg;
    logic                             out_calc_reg;
    logic                             out_passed_reg;
    logic                             out_allow_reg;
    logic [PW-1:0]                    out_phase_reg;
    logic [lcph_pkg::COLOR_W-1:0]     out_color_reg;

    logic                             advance;
    logic                             phase_ok;
    logic [CNT_W-1:0]                 live_cnt;

    // Handshake: the input stage moves on whenever the result register is free.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // A message is taken at the own phase or one ahead, with no wrap.
    assign phase_ok = (in_phase_reg == phase_reg) ||
                      ({1'b0, in_phase_reg} == ({1'b0, phase_reg} + {{PW{1'b0}}, 1'b1}));

    // One pass over the item: message update or the three phase checks in order.
    always_comb begin
        alive_next   = alive_reg;
        cnext_next   = cnext_reg;
        calc_next    = calc_reg;
        passed_next  = passed_reg;
        allow_next   = allow_reg;
        phase_next   = phase_reg;
        color_next   = color_reg;
        nknown_next  = nknown_reg;
        nalive_next  = nalive_reg;
        ncalc_next   = ncalc_reg;
        npassed_next = npassed_reg;
        nallow_next  = nallow_reg;
        live_cnt     = '0;

        if (in_cmd_reg == lcph_pkg::CMD_EVALUATE) begin
            // Calculate phase: apply the life rule.
            if (&nknown_next && &nallow_next && !calc_next) begin
                for (int i = 0; i < NEIGHBOR_COUNT; i++) begin
                    live_cnt = live_cnt + CNT_W'(nalive_next[i]);
                end
                cnext_next = ((live_cnt == CNT_W'(3)) ||
                              ((live_cnt == CNT_W'(2)) && alive_next)) ?
                             lcph_pkg::NEXT_ALIVE : lcph_pkg::NEXT_DEAD;
                calc_next    = 1'b1;
                passed_next  = 1'b0;
                color_next   = (cnext_next == lcph_pkg::NEXT_ALIVE) ?
                               lcph_pkg::COLOR_CYAN : lcph_pkg::COLOR_YELLOW;
                nknown_next  = ~present_reg;
                nalive_next  = '0;
                ncalc_next   = ~present_reg;
                npassed_next = ~present_reg;
                nallow_next  = ~present_reg;
                phase_next   = phase_next + PW'(1);
            end
            // Pass phase: commit the next state.
            if (&ncalc_next && !passed_next) begin
                alive_next   = (cnext_next == lcph_pkg::NEXT_ALIVE);
                cnext_next   = lcph_pkg::NEXT_UNKNOWN;
                allow_next   = 1'b0;
                passed_next  = 1'b1;
                color_next   = alive_next ? lcph_pkg::COLOR_BLUE : lcph_pkg::COLOR_RED;
                nknown_next  = ~present_reg;
                nalive_next  = '0;
                ncalc_next   = ~present_reg;
                npassed_next = ~present_reg;
                nallow_next  = ~present_reg;
                phase_next   = phase_next + PW'(1);
            end
            // Allow phase: ready for the next step.
            if (&npassed_next && !allow_next) begin
                allow_next   = 1'b1;
                calc_next    = 1'b0;
                color_next   = lcph_pkg::COLOR_WHITE;
                nknown_next  = ~present_reg;
                nalive_next  = '0;
                ncalc_next   = ~present_reg;
                npassed_next = ~present_reg;
                nallow_next  = ~present_reg;
                phase_next   = phase_next + PW'(1);
            end
        end else if (present_reg[in_slot_reg] && phase_ok) begin
            // Neighbor message: set record fields while the own flags allow it.
            if (!calc_reg) begin
                if (!nknown_reg[in_slot_reg]) begin
                    nknown_next[in_slot_reg] = 1'b1;
                    nalive_next[in_slot_reg] = in_alive_reg;
                end
                if (in_allow_reg) begin
                    nallow_next[in_slot_reg] = 1'b1;
                end
            end
            if (!passed_reg && in_calc_reg) begin
                ncalc_next[in_slot_reg] = 1'b1;
            end
            if (!allow_reg && in_passed_reg) begin
                npassed_next[in_slot_reg] = 1'b1;
            end
        end
    end

    // Input register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_cmd_reg    <= lcph_pkg::cmd_t'(s_command);
            in_slot_reg   <= s_sender_slot;
            in_phase_reg  <= s_msg_phase;
            in_alive_reg  <= s_msg_alive;
            in_calc_reg   <= s_msg_calc;
            in_passed_reg <= s_msg_passed;
            in_allow_reg  <= s_msg_allow;
        end
    end

    // Cell state: reset, configuration writes, then item updates.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg    <= '1;
            alive_reg      <= 1'b0;
            cnext_reg      <= lcph_pkg::NEXT_UNKNOWN;
            calc_reg       <= 1'b0;
            passed_reg     <= 1'b0;
            allow_reg      <= 1'b1;
            phase_reg      <= '0;
            color_reg      <= lcph_pkg::COLOR_YELLOW;
            nknown_reg     <= '0;
            nalive_reg     <= '0;
            ncalc_reg      <= '0;
            npassed_reg    <= '0;
            nallow_reg     <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                lcph_pkg::CFG_NEIGHBOR_PRESENT: begin
                    present_reg <= cfg_wdata;
                    nknown_reg  <= ~cfg_wdata;
                    nalive_reg  <= '0;
                    ncalc_reg   <= ~cfg_wdata;
                    npassed_reg <= ~cfg_wdata;
                    nallow_reg  <= ~cfg_wdata;
                end
                lcph_pkg::CFG_INITIAL_ALIVE: begin
                    alive_reg      <= cfg_wdata[0];
                    color_reg      <= cfg_wdata[0] ? lcph_pkg::COLOR_CYAN :
                                                     lcph_pkg::COLOR_YELLOW;
                end
                default: begin
                end
            endcase
        end else if (advance) begin
            alive_reg   <= alive_next;
            cnext_reg   <= cnext_next;
            calc_reg    <= calc_next;
            passed_reg  <= passed_next;
            allow_reg   <= allow_next;
            phase_reg   <= phase_next;
            color_reg   <= color_next;
            nknown_reg  <= nknown_next;
            nalive_reg  <= nalive_next;
            ncalc_reg   <= ncalc_next;
            npassed_reg <= npassed_next;
            nallow_reg  <= nallow_next;
        end
    end

    // Result register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload: the cell fields after this item.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_alive_reg  <= alive_next;
            out_next_reg   <= cnext_next;
            out_calc_reg   <= calc_next;
            out_passed_reg <= passed_next;
            out_allow_reg  <= allow_next;
            out_phase_reg  <= phase_next;
            out_color_reg  <= color_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_alive  = out_alive_reg;
    assign m_out_next   = out_next_reg;
    assign m_out_calc   = out_calc_reg;
    assign m_out_passed = out_passed_reg;
    assign m_out_allow  = out_allow_reg;
    assign m_out_phase  = out_phase_reg;
    assign m_led_color  = out_color_reg;

    // An empty result register never blocks the input side.
    `LCPH_ASSERT_NOW(a_ready_when_empty, aclk, aresetn, !out_valid_reg, s_ready,
        "input not ready although the result register is empty")

    // Every item that leaves the input register shows up as a result.
    `LCPH_ASSERT_NEXT(a_result_follows, aclk, aresetn, advance, out_valid_reg,
        "advanced item produced no result")

    // The phase counter moves only on an evaluate transaction.
    `LCPH_ASSERT_NEXT(a_phase_on_eval, aclk, aresetn,
        !(advance && (in_cmd_reg == lcph_pkg::CMD_EVALUATE)), $stable(phase_reg),
        "phase changed without an evaluate transaction")

    // A neighbor message never touches the own barrier flags.
    `LCPH_ASSERT_NEXT(a_msg_keeps_flags, aclk, aresetn,
        advance && !cfg_wr_en && (in_cmd_reg == lcph_pkg::CMD_MESSAGE),
        $stable(calc_reg) && $stable(passed_reg) && $stable(allow_reg),
        "neighbor message changed an own phase flag")

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for life_cell_with_phase_handshake.
// Depends on lcph_pkg and the cell RTL. A directed table comes first, then random traffic.
// Every result is checked against a directed row's status or a cycle-free model in this file.
module testbench;
    import lcph_pkg::*;

    localparam int NBR             = NEIGHBOR_COUNT_DEF;
    localparam int CONFIG_ROUNDS   = 10;
    localparam int ITEMS_PER_ROUND = 160;
    localparam int PRESSURE_ROUND  = 3;
    localparam int BURST_START     = 40;
    localparam int BURST_LEN       = 30;
    localparam int PAUSE_AT        = 100;
    localparam int LONG_HOLD       = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int DIRECTED_LEN    = 22;
    localparam int DIRECTED_CFG_ROW = 1;

    // Register indexes that the cell has no register behind.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        cmd_t                command;
        logic [SLOT_W-1:0]   slot;
        logic [PHASE_W-1:0]  phase;
        logic                alive;
        logic                calc;
        logic                passed;
        logic                allow;
    } cell_item_t;

    localparam int ITEM_W = $bits(cell_item_t);

    typedef struct packed {
        logic                alive;
        logic [NEXT_W-1:0]   next;
        logic                calc;
        logic                passed;
        logic                allow;
        logic [PHASE_W-1:0]  phase;
        logic [COLOR_W-1:0]  color;
    } cell_status_t;

    typedef struct packed {
        cell_item_t   item;
        logic         typed;
        cell_status_t want;
    } stim_row_t;

    localparam cell_status_t NO_CHECK = '0;

    // Directed rows. The first row runs on the reset configuration; the others run with
    // three neighbors present (slots 0 to 2) and walk one full calculate/pass/allow cycle.
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_LEN] = '{
        '{'{CMD_EVALUATE, 3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, NEXT_UNKNOWN, 1'b0, 1'b0, 1'b1, 8'd0, COLOR_YELLOW}},
        '{'{CMD_MESSAGE,  3'd7, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd0, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd0, 8'd0,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd1, 8'd1,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd0, 8'd1,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd2, 8'd0,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_EVALUATE, 3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b0, NEXT_ALIVE, 1'b1, 1'b0, 1'b1, 8'd1, COLOR_CYAN}},
        '{'{CMD_MESSAGE,  3'd0, 8'd0,   1'b0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd0, 8'd1,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd1, 8'd2,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_EVALUATE, 3'd7, 8'd255, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd2, 8'd2,   1'b0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_EVALUATE, 3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, NEXT_UNKNOWN, 1'b1, 1'b1, 1'b0, 8'd2, COLOR_BLUE}},
        '{'{CMD_MESSAGE,  3'd0, 8'd2,   1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd1, 8'd3,   1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd2, 8'd3,   1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_CHECK},
        '{'{CMD_EVALUATE, 3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, NEXT_UNKNOWN, 1'b0, 1'b1, 1'b1, 8'd3, COLOR_WHITE}},
        '{'{CMD_MESSAGE,  3'd0, 8'd3,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd1, 8'd4,   1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_MESSAGE,  3'd2, 8'd4,   1'b1, 1'b0, 1'b0, 1'b1}, 1'b0, NO_CHECK},
        '{'{CMD_EVALUATE, 3'd0, 8'd0,   1'b0, 1'b0, 1'b0, 1'b0}, 1'b1,
          '{1'b1, NEXT_ALIVE, 1'b1, 1'b0, 1'b1, 8'd4, COLOR_CYAN}}
    };

    // Clock, reset and every block input start at known values.
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [NBR-1:0]       cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    cmd_t                 s_command = CMD_MESSAGE;
    logic [SLOT_W-1:0]    s_sender_slot = '0;
    logic [PHASE_W-1:0]   s_msg_phase   = '0;
    logic                 s_msg_alive   = 1'b0;
    logic                 s_msg_calc    = 1'b0;
    logic                 s_msg_passed  = 1'b0;
    logic                 s_msg_allow   = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_out_alive;
    logic [NEXT_W-1:0]    m_out_next;
    logic                 m_out_calc;
    logic                 m_out_passed;
    logic                 m_out_allow;
    logic [PHASE_W-1:0]   m_out_phase;
    logic [COLOR_W-1:0]   m_led_color;

    // Statuses predicted for accepted transactions, oldest first.
    cell_status_t pending_status [$];
    int           mismatches    = 0;
    int           hold_requests = 0;
    int           holds_served  = 0;
    int           stall_left    = 0;

    // Model copy of the cell's configuration and state.
    logic [NBR-1:0]     present_mask;
    logic               cur_alive;
    logic [NEXT_W-1:0]  cur_next;
    logic               cur_calc;
    logic               cur_passed;
    logic               cur_allow;
    logic [PHASE_W-1:0] cur_phase;
    logic [COLOR_W-1:0] cur_color;
    logic [NEXT_W-1:0]  seen_state [NBR];
    logic [NBR-1:0]     seen_calc;
    logic [NBR-1:0]     seen_passed;
    logic [NBR-1:0]     seen_allow;

    life_cell_with_phase_handshake uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_sender_slot (s_sender_slot),
        .s_msg_phase   (s_msg_phase),
        .s_msg_alive   (s_msg_alive),
        .s_msg_calc    (s_msg_calc),
        .s_msg_passed  (s_msg_passed),
        .s_msg_allow   (s_msg_allow),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_alive   (m_out_alive),
        .m_out_next    (m_out_next),
        .m_out_calc    (m_out_calc),
        .m_out_passed  (m_out_passed),
        .m_out_allow   (m_out_allow),
        .m_out_phase   (m_out_phase),
        .m_led_color   (m_led_color)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Neighbor records go back to unknown for present slots and to dead and done for absent ones.
    task automatic life_reload_records();
        for (int i = 0; i < NBR; i++) begin
            seen_state[i] = present_mask[i] ? NEXT_UNKNOWN : NEXT_DEAD;
        end
        seen_calc   = ~present_mask;
        seen_passed = ~present_mask;
        seen_allow  = ~present_mask;
    endtask

    task automatic life_reset();
        present_mask = '1;
        cur_alive    = 1'b0;
        cur_next     = NEXT_UNKNOWN;
        cur_calc     = 1'b0;
        cur_passed   = 1'b0;
        cur_allow    = 1'b1;
        cur_phase    = '0;
        cur_color    = COLOR_YELLOW;
        life_reload_records();
    endtask

    task automatic life_write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [NBR-1:0] data);
        case (idx)
            CFG_NEIGHBOR_PRESENT: begin
                present_mask = data;
                life_reload_records();
            end
            CFG_INITIAL_ALIVE: begin
                cur_alive = data[0];
                cur_color = data[0] ? COLOR_CYAN : COLOR_YELLOW;
            end
            default: ;
        endcase
    endtask

    // Advances the model by one transaction and returns the status it reports.
    task automatic life_step(input cell_item_t it, output cell_status_t st);
        int   live;
        logic known;
        if (it.command == CMD_EVALUATE) begin
            known = 1'b1;
            live  = 0;
            for (int i = 0; i < NBR; i++) begin
                if (seen_state[i] == NEXT_UNKNOWN) known = 1'b0;
                live += int'(seen_state[i]);
            end
            // Calculate: every neighbor state known and every neighbor allowing.
            if (known && (&seen_allow) && !cur_calc) begin
                cur_next   = (live == 3 || (live == 2 && cur_alive)) ? NEXT_ALIVE : NEXT_DEAD;
                cur_calc   = 1'b1;
                cur_passed = 1'b0;
                cur_color  = (cur_next == NEXT_ALIVE) ? COLOR_CYAN : COLOR_YELLOW;
                life_reload_records();
                cur_phase  = cur_phase + 8'd1;
            end
            // Pass: every neighbor has calculated; an unknown next state commits as dead.
            if ((&seen_calc) && !cur_passed) begin
                cur_alive  = (cur_next == NEXT_ALIVE);
                cur_next   = NEXT_UNKNOWN;
                cur_allow  = 1'b0;
                cur_passed = 1'b1;
                cur_color  = cur_alive ? COLOR_BLUE : COLOR_RED;
                life_reload_records();
                cur_phase  = cur_phase + 8'd1;
            end
            // Allow: every neighbor has committed.
            if ((&seen_passed) && !cur_allow) begin
                cur_allow = 1'b1;
                cur_calc  = 1'b0;
                cur_color = COLOR_WHITE;
                life_reload_records();
                cur_phase = cur_phase + 8'd1;
            end
        end else if (present_mask[it.slot] &&
                     (it.phase == cur_phase || int'(it.phase) == int'(cur_phase) + 1)) begin
            // Message in the current or the next phase; the next one does not wrap.
            if (!cur_calc) begin
                if (seen_state[it.slot] == NEXT_UNKNOWN) seen_state[it.slot] = {1'b0, it.alive};
                if (it.allow) seen_allow[it.slot] = 1'b1;
            end
            if (!cur_passed && it.calc) seen_calc[it.slot] = 1'b1;
            if (!cur_allow && it.passed) seen_passed[it.slot] = 1'b1;
        end
        st = '{cur_alive, cur_next, cur_calc, cur_passed, cur_allow, cur_phase, cur_color};
    endtask

    // Idle length for the sender: mostly none or short, now and then long.
    function automatic int sender_idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // Offers one transaction, waits for the handshake and records its predicted status.
    task automatic offer(input cell_item_t it, input logic typed, input cell_status_t want);
        cell_status_t predicted;
        s_valid       <= 1'b1;
        s_command     <= it.command;
        s_sender_slot <= it.slot;
        s_msg_phase   <= it.phase;
        s_msg_alive   <= it.alive;
        s_msg_calc    <= it.calc;
        s_msg_passed  <= it.passed;
        s_msg_allow   <= it.allow;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        life_step(it, predicted);
        pending_status.push_back(typed ? want : predicted);
    endtask

    task automatic sender_gap(input int n);
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    // Sender pause until every outstanding transaction has produced its result.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes both registers, then one index that has no register behind it.
    task automatic configure(input logic [NBR-1:0] mask, input logic [NBR-1:0] init_word);
        logic [CFG_IDX_W-1:0] spare;
        spare = $urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI;
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NEIGHBOR_PRESENT;
        cfg_wdata <= mask;
        @(posedge aclk);
        life_write_reg(CFG_NEIGHBOR_PRESENT, mask);
        cfg_index <= CFG_INITIAL_ALIVE;
        cfg_wdata <= init_word;
        @(posedge aclk);
        life_write_reg(CFG_INITIAL_ALIVE, init_word);
        cfg_index <= spare;
        cfg_wdata <= NBR'($urandom);
        @(posedge aclk);
        life_write_reg(spare, cfg_wdata);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly messages in the phase window to present slots, some ticks, some noise.
    task automatic random_item(output cell_item_t it);
        logic [ITEM_W-1:0] raw;
        logic [SLOT_W-1:0] slot;
        int                r;
        raw    = ITEM_W'($urandom);
        it     = raw;
        r      = $urandom_range(99);
        if (r < 25) begin
            it.command = CMD_EVALUATE;
        end else if (r < 85) begin
            it.command = CMD_MESSAGE;
            slot = SLOT_W'($urandom_range(NBR - 1));
            if (present_mask != '0) begin
                while (!present_mask[slot]) slot = SLOT_W'($urandom_range(NBR - 1));
            end
            it.slot   = slot;
            // At phase 255 the next phase wraps to 0, which the cell must refuse.
            it.phase  = cur_phase + PHASE_W'($urandom_range(1));
            it.calc   = ($urandom_range(3) != 0);
            it.passed = ($urandom_range(3) != 0);
            it.allow  = ($urandom_range(3) != 0);
        end else begin
            it.command = CMD_MESSAGE;
        end
    endtask

    // Receiver: random ready pattern, plus a long hold-off on request from the sender.
    always @(posedge aclk) begin : receiver
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            stall_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = $urandom_range(99);
            if (r < 15) begin
                m_ready <= 1'b1;
                stall_left = $urandom_range(120, 40);
            end else if (r < 70) begin
                m_ready <= 1'b1;
                stall_left = $urandom_range(3);
            end else if (r < 95) begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(3);
            end else begin
                m_ready <= 1'b0;
                stall_left = $urandom_range(40, 10);
            end
        end
    end

    // Each accepted result is compared field by field with the oldest prediction.
    always @(posedge aclk) begin : result_check
        cell_status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                report_mismatch("result transaction with nothing outstanding");
            end else begin
                want = pending_status.pop_front();
                if (m_out_alive !== want.alive)
                    report_mismatch($sformatf("out_alive %0d, expected %0d",
                                              m_out_alive, want.alive));
                if (m_out_next !== want.next)
                    report_mismatch($sformatf("out_next %0d, expected %0d",
                                              m_out_next, want.next));
                if (m_out_calc !== want.calc)
                    report_mismatch($sformatf("out_calc %0d, expected %0d",
                                              m_out_calc, want.calc));
                if (m_out_passed !== want.passed)
                    report_mismatch($sformatf("out_passed %0d, expected %0d",
                                              m_out_passed, want.passed));
                if (m_out_allow !== want.allow)
                    report_mismatch($sformatf("out_allow %0d, expected %0d",
                                              m_out_allow, want.allow));
                if (m_out_phase !== want.phase)
                    report_mismatch($sformatf("out_phase %0d, expected %0d",
                                              m_out_phase, want.phase));
                if (m_led_color !== want.color)
                    report_mismatch($sformatf("led_color %0d, expected %0d",
                                              m_led_color, want.color));
            end
        end
    end

    // Main sequence: reset, directed table, random rounds under changing configuration.
    initial begin : stimulus
        cell_item_t     item;
        logic [NBR-1:0] mask;
        logic [NBR-1:0] init_word;
        int             count;
        int             burst_left;
        int             w;
        burst_left = 0;
        life_reset();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table; the first row sees the reset configuration.
        for (int i = 0; i < DIRECTED_LEN; i++) begin
            if (i == DIRECTED_CFG_ROW) begin
                wait_idle();
                configure(8'h07, 8'h00);
            end
            offer(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
            sender_gap(sender_idle_len());
        end

        // Random rounds, each under a fresh configuration, extremes first.
        for (int round = 0; round < CONFIG_ROUNDS; round++) begin
            wait_idle();
            case (round)
                0: begin
                    mask      = 8'h00;
                    init_word = 8'h01;
                end
                1: begin
                    mask      = 8'hFF;
                    init_word = 8'hFE;
                end
                2: begin
                    mask      = 8'h80;
                    init_word = NBR'($urandom);
                end
                default: begin
                    mask      = $urandom_range(1) ? NBR'($urandom) : NBR'(1 << $urandom_range(7));
                    init_word = NBR'($urandom);
                end
            endcase
            configure(mask, init_word);
            count = 0;
            while (count < ITEMS_PER_ROUND) begin
                random_item(item);
                offer(item, 1'b0, NO_CHECK);
                count++;
                // Stall the receiver for a long stretch while items keep coming.
                if (round == PRESSURE_ROUND && count == BURST_START) begin
                    hold_requests++;
                    burst_left = BURST_LEN;
                end
                if (burst_left > 0) begin
                    burst_left--;
                end else if (count == PAUSE_AT) begin
                    wait_idle();
                end else begin
                    sender_gap(sender_idle_len());
                end
            end
        end

        // Drain the outstanding results, then give the block time to show strays.
        s_valid <= 1'b0;
        for (w = 0; w < DRAIN_LIMIT && pending_status.size() != 0; w++) @(posedge aclk);
        repeat (2 * SETTLE_CYCLES) @(posedge aclk);
        if (pending_status.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_status.size()));
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
